/* src/assert_macros.svh */
// Assertion macros shared by the grid reachability RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/grd_pkg.sv */
// Package with sizes, neighbor codes and controller/datapath interface types.
package grd_pkg;

  // Default grid and stack sizes.
  localparam int GRID_ROWS_DEF   = 5;
  localparam int GRID_COLS_DEF   = 5;
  localparam int STACK_DEPTH_DEF = 128;

  // Fixed widths of the transaction fields.
  localparam int GRID_BITS = 25;
  localparam int POS_W     = 3;

  // Neighbor codes, visited in this order around the current cell.
  localparam logic [1:0] NBR_LEFT  = 2'd0;
  localparam logic [1:0] NBR_RIGHT = 2'd1;
  localparam logic [1:0] NBR_UP    = 2'd2;
  localparam logic [1:0] NBR_DOWN  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new input transaction
    logic push_start;  // push the start cell onto the empty stack
    logic pop;         // pop the top entry and start its read
    logic take_cur;    // latch the popped cell as the current cell
    logic nbr_step;    // examine one neighbor, push it if eligible
    logic set_res;     // record the search outcome
    logic res_val;     // outcome value for set_res
    logic out_load;    // move the outcome into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_ok;     // start and goal in range and both free
    logic stack_empty;  // no entries on the stack
    logic cur_visited;  // popped cell was already expanded
    logic cur_is_goal;  // popped cell is the goal
    logic last_nbr;     // the neighbor being examined is the last one
  } status_t;

endpackage

/* src/grid_reachability_dfs.sv */
// Grid reachability by depth-first search. Each input transaction carries a
// packed grid (bit row*GRID_COLS+col set means blocked), a start cell and a
// goal cell; one output transaction answers whether the goal is reachable
// through free cells with four-way moves. A blocked or out-of-range start or
// goal answers 0, and grid cells past bit 24 read as free. A cell is marked
// visited as soon as its neighbors have been pushed, so each edge of the grid
// causes at most one push; on a 5x5 grid the number of stack pops is at most
// 41. The search is paced by the single stack memory: one push or one pop per
// cycle, a registered read after each pop, and one neighbor examined per
// cycle. A new transaction is taken once the previous search has handed its
// result to the output register, even while that result is still stalled.
module grid_reachability_dfs
  import grd_pkg::*;
#(
  parameter int GRID_ROWS   = GRID_ROWS_DEF,
  parameter int GRID_COLS   = GRID_COLS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [GRID_BITS-1:0] grid_cells,
  input  logic [POS_W-1:0]     start_row,
  input  logic [POS_W-1:0]     start_col,
  input  logic [POS_W-1:0]     goal_row,
  input  logic [POS_W-1:0]     goal_col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 reachable
);

  cmd_t    cmd;
  status_t status;

  // Search sequencer.
  grd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Grid, visited map and stack.
  grd_dp #(
    .GRID_ROWS   (GRID_ROWS),
    .GRID_COLS   (GRID_COLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .grid_cells (grid_cells),
    .start_row  (start_row),
    .start_col  (start_col),
    .goal_row   (goal_row),
    .goal_col   (goal_col),
    .reachable  (reachable)
  );

endmodule

/* src/grd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module grd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/grd_ctrl.sv */
// Controller state machine that sequences the depth-first search.
`include "assert_macros.svh"

module grd_ctrl
  import grd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_POP   = 6'b000100,
    S_EXAM  = 6'b001000,
    S_NBR   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   in_take;
  logic   out_free;

  // New transactions are taken only between searches.
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.start_ok) begin
          cmd.push_start = 1'b1;
          state_next     = S_POP;
        end else begin
          cmd.set_res = 1'b1;
          cmd.res_val = 1'b0;
          state_next  = S_DONE;
        end
      end
      S_POP: begin
        if (status.stack_empty) begin
          cmd.set_res = 1'b1;
          cmd.res_val = 1'b0;
          state_next  = S_DONE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_EXAM;
        end
      end
      S_EXAM: begin
        if (status.cur_visited) begin
          state_next = S_POP;
        end else if (status.cur_is_goal) begin
          cmd.set_res = 1'b1;
          cmd.res_val = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.take_cur = 1'b1;
          state_next   = S_NBR;
        end
      end
      S_NBR: begin
        cmd.nbr_step = 1'b1;
        if (status.last_nbr) begin
          state_next = S_POP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid holds while the result transaction is stalled.
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // An accepted transaction always starts the range and blocking check.
  `AST_NXT(a_take_to_check, in_take, state == S_CHECK, "accepted transaction did not start check")
  // A finished search whose output slot is free always presents a result.
  `AST_NXT(a_done_presents, (state == S_DONE) && out_free, out_valid, "result not presented")

endmodule

/* src/grd_dp.sv */
// Datapath: held grid, visited map, stack memory and neighbor generation.
`include "assert_macros.svh"

module grd_dp
  import grd_pkg::*;
#(
  parameter int GRID_ROWS   = GRID_ROWS_DEF,
  parameter int GRID_COLS   = GRID_COLS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [GRID_BITS-1:0] grid_cells,
  input  logic [POS_W-1:0]     start_row,
  input  logic [POS_W-1:0]     start_col,
  input  logic [POS_W-1:0]     goal_row,
  input  logic [POS_W-1:0]     goal_col,
  output logic                 reachable
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int IDX_W = $clog2(CELLS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);

  logic [GRID_BITS-1:0] held_grid;
  logic [CELLS-1:0]     grid_ext;
  logic [CELLS-1:0]     visited;
  logic [IDX_W-1:0]     start_idx;
  logic [IDX_W-1:0]     goal_idx;
  logic                 in_range;
  logic [LVL_W-1:0]     level;
  logic [IDX_W-1:0]     cur;
  logic [ROW_W-1:0]     cur_row;
  logic [COL_W-1:0]     cur_col;
  logic [1:0]           nbr_k;
  logic                 res_bit;

  logic                 load_range;
  logic [IDX_W-1:0]     load_start;
  logic [IDX_W-1:0]     load_goal;
  logic [IDX_W-1:0]     rd_cell;
  logic [ROW_W-1:0]     rd_row;
  logic [COL_W-1:0]     rd_col;
  logic                 nbr_ok;
  logic [IDX_W-1:0]     nbr_cell;
  logic                 stack_full;
  logic                 push_nbr;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_wdata;
  logic [AW-1:0]        pop_addr;

  // Cells past the grid field read as free.
  for (genvar i = 0; i < CELLS; i++) begin : g_grid
    if (i < GRID_BITS) begin : g_in
      assign grid_ext[i] = held_grid[i];
    end else begin : g_out
      assign grid_ext[i] = 1'b0;
    end
  end

  // Range check and linear cell indices of the incoming start and goal.
  always_comb begin
    load_range = (int'(start_row) < GRID_ROWS) && (int'(start_col) < GRID_COLS) &&
                 (int'(goal_row) < GRID_ROWS) && (int'(goal_col) < GRID_COLS);
    load_start = IDX_W'(int'(start_row) * GRID_COLS + int'(start_col));
    load_goal  = IDX_W'(int'(goal_row) * GRID_COLS + int'(goal_col));
  end

  // Row and column of the popped cell by comparison against row boundaries.
  always_comb begin
    rd_row = '0;
    for (int j = 1; j < GRID_ROWS; j++) begin
      if (int'(rd_cell) >= j * GRID_COLS) begin
        rd_row = ROW_W'(j);
      end
    end
    rd_col = COL_W'(int'(rd_cell) - int'(rd_row) * GRID_COLS);
  end

  // Neighbor of the current cell selected by the neighbor counter.
  always_comb begin
    nbr_ok   = 1'b0;
    nbr_cell = cur;
    case (nbr_k)
      NBR_LEFT: begin
        nbr_ok   = (cur_col != '0);
        nbr_cell = cur - IDX_W'(1);
      end
      NBR_RIGHT: begin
        nbr_ok   = (int'(cur_col) < GRID_COLS - 1);
        nbr_cell = cur + IDX_W'(1);
      end
      NBR_UP: begin
        nbr_ok   = (cur_row != '0);
        nbr_cell = cur - IDX_W'(GRID_COLS);
      end
      NBR_DOWN: begin
        nbr_ok   = (int'(cur_row) < GRID_ROWS - 1);
        nbr_cell = cur + IDX_W'(GRID_COLS);
      end
      default: begin
        nbr_ok = 1'b0;
      end
    endcase
  end

  // A push onto a full stack is dropped.
  assign stack_full = (level == LVL_W'(STACK_DEPTH));
  assign push_nbr   = cmd.nbr_step && nbr_ok && !visited[nbr_cell] &&
                      !grid_ext[nbr_cell] && !stack_full;

  // Stack memory port control.
  assign ram_we    = cmd.push_start || push_nbr;
  assign ram_wdata = cmd.push_start ? start_idx : nbr_cell;
  assign pop_addr  = AW'(level - LVL_W'(1));

  grd_ram #(
    .WIDTH (IDX_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (level[AW-1:0]),
    .wdata (ram_wdata),
    .re    (cmd.pop),
    .raddr (pop_addr),
    .rdata (rd_cell)
  );

  // Status back to the controller.
  assign status.start_ok    = in_range && !grid_ext[start_idx] && !grid_ext[goal_idx];
  assign status.stack_empty = (level == '0);
  assign status.cur_visited = visited[rd_cell];
  assign status.cur_is_goal = (rd_cell == goal_idx);
  assign status.last_nbr    = (nbr_k == NBR_DOWN);

  // Stack level, visited map and neighbor counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      visited <= '0;
      nbr_k   <= NBR_LEFT;
    end else begin
      if (cmd.load) begin
        level   <= '0;
        visited <= '0;
      end else if (cmd.push_start) begin
        level <= LVL_W'(1);
      end else if (cmd.pop) begin
        level <= level - LVL_W'(1);
      end else if (push_nbr) begin
        level <= level + LVL_W'(1);
      end
      if (cmd.nbr_step && status.last_nbr) begin
        visited[cur] <= 1'b1;
      end
      if (cmd.take_cur) begin
        nbr_k <= NBR_LEFT;
      end else if (cmd.nbr_step) begin
        nbr_k <= nbr_k + 2'd1;
      end
    end
  end

  // Transaction payload, current cell and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_grid <= grid_cells;
      start_idx <= load_start;
      goal_idx  <= load_goal;
      in_range  <= load_range;
    end
    if (cmd.take_cur) begin
      cur     <= rd_cell;
      cur_row <= rd_row;
      cur_col <= rd_col;
    end
    if (cmd.set_res) begin
      res_bit <= cmd.res_val;
    end
    if (cmd.out_load) begin
      reachable <= res_bit;
    end
  end

  // The stack level never passes the memory depth.
  `AST_IMP(a_level_bound, 1'b1, level <= LVL_W'(STACK_DEPTH), "stack level past depth")
  // Every search begins with an empty visited map.
  `AST_NXT(a_visited_clear, cmd.load, visited == '0, "visited map not cleared")
  // Finishing the last neighbor marks the current cell as expanded.
  `AST_NXT(a_mark_visited, cmd.nbr_step && status.last_nbr, visited[cur], "cell not marked")

endmodule

/* bench/grid_reachability_dfs_tb.sv */
// Self-checking testbench for the grid reachability block: directed and random mazes.
module grid_reachability_dfs_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grd_pkg::*;

  localparam int ROWS = GRID_ROWS_DEF;
  localparam int COLS = GRID_COLS_DEF;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 400;
  localparam int MAX_PRINTED = 200;
  localparam logic [GRID_BITS-1:0] ALL_FREE = '0;
  localparam logic [GRID_BITS-1:0] ALL_BLOCKED = '1;

  // One maze query as it travels on the input channel.
  typedef struct {
    logic [GRID_BITS-1:0] grid;
    logic [POS_W-1:0]     sr;
    logic [POS_W-1:0]     sc;
    logic [POS_W-1:0]     gr;
    logic [POS_W-1:0]     gc;
  } maze_query_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [GRID_BITS-1:0] grid_cells = '0;
  logic [POS_W-1:0]     start_row = '0;
  logic [POS_W-1:0]     start_col = '0;
  logic [POS_W-1:0]     goal_row = '0;
  logic [POS_W-1:0]     goal_col = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 reachable;

  maze_query_t query_fifo[$];
  bit          answer_fifo[$];
  maze_query_t next_query;
  bit          want_answer;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  logic        hold_go = 1'b0;
  int          error_count = 0;

  grid_reachability_dfs dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .grid_cells (grid_cells),
    .start_row  (start_row),
    .start_col  (start_col),
    .goal_row   (goal_row),
    .goal_col   (goal_col),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reachable  (reachable)
  );

  always #6 clk = ~clk;

  // Flood fill from the start cell through free cells; the goal is reachable
  // when the fill covers it. Out-of-range or blocked endpoints answer no.
  function automatic bit goal_reachable(logic [GRID_BITS-1:0] blocked,
                                        logic [POS_W-1:0] sr, logic [POS_W-1:0] sc,
                                        logic [POS_W-1:0] gr, logic [POS_W-1:0] gc);
    logic [GRID_BITS-1:0] seen;
    logic [GRID_BITS-1:0] grown;
    int src;
    int dst;
    int r;
    int c;
    if (sr >= ROWS || sc >= COLS || gr >= ROWS || gc >= COLS) return 1'b0;
    src = sr * COLS + sc;
    dst = gr * COLS + gc;
    if (blocked[src] || blocked[dst]) return 1'b0;
    seen = '0;
    seen[src] = 1'b1;
    repeat (ROWS * COLS) begin
      grown = seen;
      for (int i = 0; i < ROWS * COLS; i++) begin
        if (seen[i]) begin
          r = i / COLS;
          c = i % COLS;
          if (c > 0 && !blocked[i-1]) grown[i-1] = 1'b1;
          if (c < COLS - 1 && !blocked[i+1]) grown[i+1] = 1'b1;
          if (r > 0 && !blocked[i-COLS]) grown[i-COLS] = 1'b1;
          if (r < ROWS - 1 && !blocked[i+COLS]) grown[i+COLS] = 1'b1;
        end
      end
      seen = grown;
    end
    return seen[dst];
  endfunction

  task automatic flag_mismatch(string what);
    if (error_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic add_query(logic [GRID_BITS-1:0] grid, int sr, int sc, int gr, int gc);
    maze_query_t q;
    q.grid = grid;
    q.sr = sr[POS_W-1:0];
    q.sc = sc[POS_W-1:0];
    q.gr = gr[POS_W-1:0];
    q.gc = gc[POS_W-1:0];
    query_fifo.push_back(q);
  endtask

  // Mostly in-range coordinates, now and then any 3-bit value.
  function automatic int pick_pos();
    if ($urandom_range(9) == 0) return $urandom_range(7);
    return $urandom_range(ROWS - 1);
  endfunction

  // Random grids of varied density; most queries get free endpoints so the
  // search actually walks the maze.
  task automatic add_random_queries(int count);
    logic [GRID_BITS-1:0] grid;
    int density;
    int sr;
    int sc;
    int gr;
    int gc;
    repeat (count) begin
      case ($urandom_range(5))
        0: density = 0;
        1: density = 15;
        2: density = 30;
        3: density = 40;
        4: density = 55;
        default: density = 80;
      endcase
      for (int i = 0; i < GRID_BITS; i++) grid[i] = ($urandom_range(99) < density);
      sr = pick_pos();
      sc = pick_pos();
      gr = pick_pos();
      gc = pick_pos();
      if ($urandom_range(99) < 80) begin
        if (sr < ROWS && sc < COLS) grid[sr*COLS+sc] = 1'b0;
        if (gr < ROWS && gc < COLS) grid[gr*COLS+gc] = 1'b0;
      end
      add_query(grid, sr, sc, gr, gc);
    end
  endtask

  // Checked on the falling edge, after the clocked processes have settled.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (query_fifo.size() != 0 || in_valid || answer_fifo.size() != 0);
  endtask

  // Sender: predicts on acceptance, then offers the next pending query.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want_answer = goal_reachable(grid_cells, start_row, start_col, goal_row, goal_col);
        answer_fifo.push_back(want_answer);
      end
      if (!in_valid || !in_stall) begin
        if (query_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_query = query_fifo.pop_front();
          grid_cells <= next_query.grid;
          start_row <= next_query.sr;
          start_col <= next_query.sc;
          goal_row <= next_query.gr;
          goal_col <= next_query.gc;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall: random back-pressure plus the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: every accepted answer must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (answer_fifo.size() == 0) begin
        flag_mismatch("answer transaction with no query outstanding");
      end else if (reachable !== answer_fifo[0]) begin
        flag_mismatch($sformatf("reachable got %b expected %b", reachable, answer_fifo[0]));
        void'(answer_fifo.pop_front());
      end else begin
        void'(answer_fifo.pop_front());
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 63;

    // Directed mazes: endpoints, walls, corridors and out-of-range positions.
    add_query(ALL_FREE, 2, 2, 2, 2);
    add_query(ALL_FREE, 0, 0, 4, 4);
    add_query(ALL_FREE, 4, 0, 0, 4);
    add_query(ALL_BLOCKED, 0, 0, 4, 4);
    add_query(ALL_BLOCKED, 3, 3, 3, 3);
    add_query(25'h1FFEFFF, 2, 2, 2, 2);
    add_query(25'h0000001, 0, 0, 4, 4);
    add_query(25'h1000000, 0, 0, 4, 4);
    add_query(25'h1000000, 0, 0, 4, 3);
    add_query(25'h0421084, 0, 0, 0, 4);
    add_query(25'h0021084, 0, 0, 0, 4);
    add_query(25'h00F01E0, 0, 0, 4, 4);
    add_query(25'h0022880, 0, 0, 2, 2);
    add_query(25'h0AAAAAA, 0, 0, 0, 2);
    add_query(25'h1555555, 0, 1, 1, 0);
    add_query(ALL_FREE, 5, 0, 0, 0);
    add_query(ALL_FREE, 0, 7, 0, 0);
    add_query(ALL_FREE, 0, 0, 6, 0);
    add_query(ALL_FREE, 0, 0, 0, 5);
    add_query(ALL_FREE, 7, 7, 7, 7);
    add_query(ALL_FREE, 4, 4, 0, 0);
    add_random_queries(200);
    wait_for_drain();

    // Sender idles more than the receiver stalls.
    send_idle_pct = 63;
    recv_idle_pct = 17;
    add_random_queries(220);
    wait_for_drain();

    // No idling; the receiver holds off long enough for the input to back up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    add_random_queries(230);
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && answer_fifo.size() == 0) begin
      $display("grid_reachability_dfs: match");
    end else begin
      $display("grid_reachability_dfs: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #12ms;
    $display("grid_reachability_dfs: mismatch");
    $finish;
  end

endmodule

/* grid_reachability_dfs.f */
+incdir+src
src/grd_pkg.sv
src/grd_ram.sv
src/grd_ctrl.sv
src/grd_dp.sv
src/grid_reachability_dfs.sv
bench/grid_reachability_dfs_tb.sv
